// ===== design/mcpwm_pkg.sv =====
// Shared types and constants of the multi-channel PWM generator.
`default_nettype none

package mcpwm_pkg;

  localparam int PIN_W   = 4;
  localparam int TICK_W  = 16;
  localparam int DUTY_W  = 16;
  localparam int LEVEL_W = 16;

  localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd2000;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Actions broadcast from the controller to the row of channel cells.
  typedef struct packed {
    logic alloc;
    logic clear;
    logic write;
    logic latch;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/mcpwm_cell.sv =====
// One channel cell: table entry, latched high time and its link to the neighbor cells.
`default_nettype none

module mcpwm_cell #(
  parameter bit INIT_VALID = 1'b0
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mcpwm_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic                              sel_i,
  input  wire logic [mcpwm_pkg::PIN_W-1:0]       pin_i,
  input  wire logic [mcpwm_pkg::TICK_W-1:0]      high_i,
  input  wire logic                              full_i,
  input  wire logic [mcpwm_pkg::TICK_W-1:0]      phase_i,
  input  wire logic                              free_seen_i,
  input  wire logic [mcpwm_pkg::LEVEL_W-1:0]     levels_i,
  output logic                                   free_seen_o,
  output logic                                   first_free_o,
  output logic                                   match_o,
  output logic                                   valid_o,
  output logic [mcpwm_pkg::LEVEL_W-1:0]          levels_o
);
  import mcpwm_pkg::*;

  logic              valid_r;
  logic [PIN_W-1:0]  pin_r;
  logic [TICK_W-1:0] high_r;
  logic              full_r;
  logic [TICK_W-1:0] act_high_r;
  logic              act_full_r;
  logic              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= INIT_VALID;
      pin_r      <= '0;
      high_r     <= '0;
      full_r     <= 1'b0;
      act_high_r <= '0;
      act_full_r <= 1'b0;
    end else begin
      if (ctrl_i.latch) begin
        act_high_r <= high_r;
        act_full_r <= full_r;
      end
      if (sel_i && ctrl_i.alloc) begin
        valid_r    <= 1'b1;
        pin_r      <= pin_i;
        act_high_r <= '0;
        act_full_r <= 1'b0;
      end
      if (sel_i && ctrl_i.clear) begin
        valid_r    <= 1'b0;
        pin_r      <= '0;
        high_r     <= '0;
        full_r     <= 1'b0;
        act_high_r <= '0;
        act_full_r <= 1'b0;
      end
      if (sel_i && ctrl_i.write) begin
        high_r <= high_i;
        full_r <= full_i;
      end
    end
  end

  // The first free entry is the one with no free entry ahead of it in the row.
  assign first_free_o = !valid_r && !free_seen_i;
  assign free_seen_o  = free_seen_i || !valid_r;
  assign match_o      = valid_r && (pin_r == pin_i);
  assign valid_o      = valid_r;

  assign hit      = valid_r && (act_full_r || (phase_i < act_high_r));
  assign levels_o = levels_i | (hit ? (LEVEL_W'(1) << pin_r) : '0);

endmodule

`default_nettype wire

// ===== design/mcpwm_div.sv =====
// High-time unit: period times duty, then a reciprocal multiplication that divides by the duty depth.
`default_nettype none

module mcpwm_div #(
  parameter int DUTY_DEPTH = 1023
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start_i,
  input  wire logic [mcpwm_pkg::TICK_W-1:0]  period_i,
  input  wire logic [mcpwm_pkg::TICK_W-1:0]  duty_i,
  output logic                               done_o,
  output logic [mcpwm_pkg::TICK_W-1:0]       high_o,
  output logic                               full_o
);
  import mcpwm_pkg::*;

  // The duty is already clamped to the depth, so the product stays below 2^(16+L).
  // A reciprocal rounded up with K fraction bits then gives the exact floor quotient.
  localparam int L_W    = $clog2(DUTY_DEPTH);
  localparam int X_W    = TICK_W + L_W;
  localparam int K      = X_W + L_W;
  localparam int M_W    = X_W + 1;
  localparam int PROD_W = X_W + M_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << K) + 64'(DUTY_DEPTH) - 64'd1) / 64'(DUTY_DEPTH);
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_WIDE);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_MUL   = 4'b0010,
    D_RECIP = 4'b0100,
    D_SHIFT = 4'b1000
  } div_state_t;

  div_state_t        state_r;
  logic [TICK_W-1:0] p_r;
  logic [TICK_W-1:0] d_r;
  logic [X_W-1:0]    x_r;
  logic [PROD_W-1:0] prod_r;
  logic [TICK_W-1:0] q_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start_i) begin
            p_r     <= period_i;
            d_r     <= duty_i;
            state_r <= D_MUL;
          end
        end
        D_MUL: begin
          x_r     <= X_W'((2*TICK_W)'(p_r) * (2*TICK_W)'(d_r));
          state_r <= D_RECIP;
        end
        D_RECIP: begin
          prod_r  <= PROD_W'(x_r) * PROD_W'(RECIP);
          state_r <= D_SHIFT;
        end
        D_SHIFT: begin
          q_r     <= prod_r[K +: TICK_W];
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign full_o = q_r >= p_r;
  assign high_o = full_o ? '0 : q_r;

endmodule

`default_nettype wire

// ===== design/multi_channel_pwm_generator_unit.sv =====
// Top level of the multi-channel PWM generator: command sequencer, period counter and cell row.
`default_nettype none

// A command is taken when start is high and busy is low. A tick, a release, a set that
// is refused and an unused opcode go from EXEC to REPLY and back to IDLE; a set that
// reaches the table also goes through DIV and WRITE and waits in DIV for the high-time unit
// that multiplies period by duty and divides by the duty depth with a reciprocal multiply.
// Each command yields one result, shown for one cycle with out_valid; the receiver
// cannot stall it and must take it in that cycle.
// The channel table is a row of MAX_CHANNELS cells searched in one pass along the row.
module multi_channel_pwm_generator_unit #(
  parameter int MAX_CHANNELS = 8,
  parameter int DUTY_DEPTH   = 1023,
  parameter int NUM_PINS     = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_opcode,
  input  wire logic [mcpwm_pkg::PIN_W-1:0]          in_pin,
  input  wire logic signed [mcpwm_pkg::DUTY_W-1:0]  in_duty,
  input  wire logic                                 cfg_we,
  input  wire logic [mcpwm_pkg::TICK_W-1:0]         cfg_wdata,
  output logic                                      out_valid,
  output logic [mcpwm_pkg::LEVEL_W-1:0]             out_pin_levels,
  output logic [1:0]                                out_status,
  output logic                                      out_running
);
  import mcpwm_pkg::*;

  localparam logic [TICK_W-1:0]  DEPTH_V  = TICK_W'(DUTY_DEPTH);
  localparam logic [LEVEL_W-1:0] PIN_MASK = LEVEL_W'((17'd1 << NUM_PINS) - 17'd1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_DIV   = 5'b00100,
    S_WRITE = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [1:0]               op_r;
  logic [PIN_W-1:0]         pin_r;
  logic signed [DUTY_W-1:0] duty_r;
  logic [TICK_W-1:0]        period_r;
  logic [TICK_W-1:0]        phase_r, phase_nxt;
  logic                     running_r, running_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [MAX_CHANNELS-1:0]  sel_r, sel_nxt;
  logic                     out_valid_r;
  logic [LEVEL_W-1:0]       out_levels_r;
  logic [1:0]               out_status_r;
  logic                     out_running_r;

  cell_ctrl_t               ctrl;
  logic [MAX_CHANNELS-1:0]  cell_sel;
  logic [MAX_CHANNELS-1:0]  match_vec;
  logic [MAX_CHANNELS-1:0]  first_free_vec;
  logic [MAX_CHANNELS-1:0]  valid_vec;
  logic [MAX_CHANNELS:0]    free_chain;
  logic [LEVEL_W-1:0]       lvl_chain [MAX_CHANNELS+1];
  logic                     pin_ok;
  logic                     match_any;
  logic                     free_any;
  logic [TICK_W-1:0]        eff_period;
  logic [TICK_W-1:0]        duty_clamp;
  logic                     div_start;
  logic                     div_done;
  logic [TICK_W-1:0]        div_high;
  logic                     div_full;

  assign pin_ok     = {1'b0, pin_r} < (PIN_W+1)'(NUM_PINS);
  assign match_any  = |match_vec;
  assign free_any   = |first_free_vec;
  assign eff_period = (period_r == '0) ? TICK_W'(1) : period_r;

  always_comb begin
    if (duty_r < 16'sd1) begin
      duty_clamp = '0;
    end else if (TICK_W'(duty_r) > DEPTH_V) begin
      duty_clamp = DEPTH_V;
    end else begin
      duty_clamp = TICK_W'(duty_r);
    end
  end

  assign free_chain[0] = 1'b0;
  assign lvl_chain[0]  = '0;

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_cell
    mcpwm_cell #(
      .INIT_VALID(g == 0)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl),
      .sel_i        (cell_sel[g]),
      .pin_i        (pin_r),
      .high_i       (div_high),
      .full_i       (div_full),
      .phase_i      (phase_r),
      .free_seen_i  (free_chain[g]),
      .levels_i     (lvl_chain[g]),
      .free_seen_o  (free_chain[g+1]),
      .first_free_o (first_free_vec[g]),
      .match_o      (match_vec[g]),
      .valid_o      (valid_vec[g]),
      .levels_o     (lvl_chain[g+1])
    );
  end

  mcpwm_div #(
    .DUTY_DEPTH(DUTY_DEPTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (div_start),
    .period_i (eff_period),
    .duty_i   (duty_clamp),
    .done_o   (div_done),
    .high_o   (div_high),
    .full_o   (div_full)
  );

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    sel_nxt     = sel_r;
    running_nxt = running_r;
    phase_nxt   = phase_r;
    ctrl        = '0;
    cell_sel    = sel_r;
    div_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_EXEC;
          status_nxt = ST_OK;
        end
      end
      S_EXEC: begin
        state_nxt = S_REPLY;
        unique case (op_r)
          OP_TICK: begin
            if (running_r && (phase_r == '0)) begin
              ctrl.latch = 1'b1;
            end
          end
          OP_SET: begin
            if (!pin_ok) begin
              status_nxt = ST_NOT_FOUND;
            end else if (match_any) begin
              sel_nxt   = match_vec;
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else if (free_any) begin
              cell_sel   = first_free_vec;
              ctrl.alloc = 1'b1;
              sel_nxt    = first_free_vec;
              div_start  = 1'b1;
              state_nxt  = S_DIV;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          OP_RELEASE: begin
            if (pin_ok && match_any) begin
              cell_sel   = match_vec;
              ctrl.clear = 1'b1;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
            // The counter stops once the table is left empty.
            if (pin_ok && !(|(valid_vec & ~match_vec))) begin
              running_nxt = 1'b0;
              phase_nxt   = '0;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ctrl.write = 1'b1;
        if (!running_r) begin
          running_nxt = 1'b1;
          phase_nxt   = '0;
        end
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        state_nxt = S_IDLE;
        if ((op_r == OP_TICK) && running_r) begin
          phase_nxt = (({1'b0, phase_r} + 17'd1) >= {1'b0, eff_period}) ? '0
                    : phase_r + TICK_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      phase_r     <= '0;
      running_r   <= 1'b0;
      status_r    <= ST_OK;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      running_r   <= running_nxt;
      status_r    <= status_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= (state_r == S_REPLY);
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_TICK;
      pin_r  <= '0;
      duty_r <= '0;
    end else if ((state_r == S_IDLE) && start) begin
      op_r   <= in_opcode;
      pin_r  <= in_pin;
      duty_r <= in_duty;
    end
    if (state_r == S_REPLY) begin
      out_levels_r  <= running_r ? (lvl_chain[MAX_CHANNELS] & PIN_MASK) : '0;
      out_status_r  <= status_r;
      out_running_r <= running_r;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_levels_r;
  assign out_status     = out_status_r;
  assign out_running    = out_running_r;

  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (phase_r == '0))
    else $error("phase counter moved while the counter is stopped");

  a_running_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (|valid_vec))
    else $error("counter running with an empty channel table");

  a_unique_pin: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("a pin is held by more than one channel entry");

  a_write_one_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> $onehot(sel_r))
    else $error("high-time write does not address exactly one entry");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire
